[rtl/nlr_pkg.sv]
package nlr_pkg;

  // scan phases
  typedef logic [2:0] phase_t;
  localparam phase_t PH_WS       = 3'd0;
  localparam phase_t PH_SIGN     = 3'd1;
  localparam phase_t PH_INT      = 3'd2;
  localparam phase_t PH_FRAC     = 3'd3;
  localparam phase_t PH_EXP_WS   = 3'd4;
  localparam phase_t PH_EXP_SIGN = 3'd5;
  localparam phase_t PH_EXP_DIG  = 3'd6;
  localparam phase_t PH_DONE     = 3'd7;

  // config register indexes
  localparam logic [1:0] REG_NUMBER_KIND = 2'd0;
  localparam logic [1:0] REG_DELIM_LOW   = 2'd1;
  localparam logic [1:0] REG_DELIM_HIGH  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef struct packed {
    logic nul;
    logic ws;
    logic dig;
    logic sign;
    logic dot;
    logic expo;
    logic delim;
  } char_class_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] end_offset;
  } result_t;

endpackage

[rtl/numeric_literal_recognizer.sv]
// Numeric literal recognizer.
// Input channel: one character beat per cycle on in_char_in (in_valid/in_stall).
// Strings are nul-terminated; each string yields exactly one verdict beat on
// out_accepted/out_end_offset, issued at the character that decides it.
// Characters after the verdict, up to the nul, produce no beat.
// cfg_wr_en/cfg_index/cfg_wdata write number_kind (0), delim_mask_low (1) and
// delim_mask_high (2); other indexes are ignored. Write only while idle.
// A deciding character's verdict is registered in the output register, or in
// the skid entry while that register is held. Throughput: one character per
// cycle while in_stall is low; scanner state updates on every accepted beat.
// Stall: results land in an output register backed by one skid entry;
// in_stall rises only when both are full, so one stalled result does not
// hold up the character stream.
// Reset (rst_n low, synchronous): scanner back to leading whitespace, offset
// zero, output buffer empty, registers at number_kind=0, low mask=1 (nul),
// high mask=0.
module numeric_literal_recognizer import nlr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [15:0] out_end_offset,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic        number_kind_r;
  logic [63:0] delim_low_r;
  logic [63:0] delim_high_r;

  char_class_t cls;
  logic        step;
  logic        buf_full;
  logic        vrd_valid;
  result_t     vrd;
  result_t     res;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_kind_r <= 1'b0;
      delim_low_r   <= 64'd1;
      delim_high_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NUMBER_KIND: number_kind_r <= cfg_wdata[0];
        REG_DELIM_LOW:   delim_low_r   <= cfg_wdata;
        REG_DELIM_HIGH:  delim_high_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // stall only when the skid entry is occupied
  assign in_stall = buf_full;
  assign step     = in_valid && !buf_full;

  nlr_char_class u_class (
    .char_in    (in_char_in),
    .delim_low  (delim_low_r),
    .delim_high (delim_high_r),
    .cls        (cls)
  );

  // scan state advances on every accepted beat
  nlr_scanner u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .flt           (number_kind_r),
    .cls           (cls),
    .verdict_valid (vrd_valid),
    .verdict       (vrd)
  );

  nlr_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (vrd_valid),
    .push_data (vrd),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_data  (res),
    .out_stall (out_stall)
  );

  assign out_accepted   = res.accepted;
  assign out_end_offset = res.end_offset;

endmodule

[rtl/nlr_char_class.sv]
module nlr_char_class import nlr_pkg::*; (
  input  logic [7:0]  char_in,
  input  logic [63:0] delim_low,
  input  logic [63:0] delim_high,
  output char_class_t cls
);

  always_comb begin
    cls.nul   = (char_in == CH_NUL);
    cls.ws    = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
    cls.dig   = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    cls.sign  = (char_in == CH_PLUS) || (char_in == CH_MINUS);
    cls.dot   = (char_in == CH_DOT);
    cls.expo  = (char_in == CH_E_LO) || (char_in == CH_E_UP);
    // codes 128..255 never terminate
    case (char_in[7:6])
      2'b00:   cls.delim = cls.nul || delim_low[char_in[5:0]];
      2'b01:   cls.delim = delim_high[char_in[5:0]];
      default: cls.delim = 1'b0;
    endcase
  end

endmodule

[rtl/nlr_scanner.sv]
module nlr_scanner import nlr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        flt,
  input  char_class_t cls,
  output logic        verdict_valid,
  output result_t     verdict
);

  phase_t      phase_r, phase_nxt;
  logic        mant_r, mant_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic        judged;
  logic        ok;

  always_comb begin
    phase_nxt = phase_r;
    mant_nxt  = mant_r;
    judged    = 1'b0;
    ok        = 1'b0;
    case (phase_r)
      PH_WS, PH_SIGN: begin
        if ((phase_r == PH_WS) && cls.ws) begin
        end else if ((phase_r == PH_WS) && cls.sign) begin
          phase_nxt = PH_SIGN;
        end else if (cls.dig) begin
          mant_nxt  = 1'b1;
          phase_nxt = PH_INT;
        end else if (flt && cls.dot) begin
          phase_nxt = PH_FRAC;
        end else begin
          judged = 1'b1;
        end
      end
      PH_INT: begin
        if (cls.dig) begin
        end else if (flt && cls.dot) begin
          phase_nxt = PH_FRAC;
        end else if (flt && cls.expo) begin
          phase_nxt = PH_EXP_WS;
        end else begin
          judged = 1'b1;
          ok     = cls.delim;
        end
      end
      PH_FRAC: begin
        if (cls.dig) begin
          mant_nxt = 1'b1;
        end else if (!mant_r) begin
          judged = 1'b1;
        end else if (cls.expo) begin
          phase_nxt = PH_EXP_WS;
        end else begin
          judged = 1'b1;
          ok     = cls.delim;
        end
      end
      PH_EXP_WS: begin
        if (cls.ws) begin
        end else if (cls.sign) begin
          phase_nxt = PH_EXP_SIGN;
        end else if (cls.dig) begin
          phase_nxt = PH_EXP_DIG;
        end else begin
          judged = 1'b1;
        end
      end
      PH_EXP_SIGN: begin
        if (cls.dig) phase_nxt = PH_EXP_DIG;
        else judged = 1'b1;
      end
      PH_EXP_DIG: begin
        if (!cls.dig) begin
          judged = 1'b1;
          ok     = cls.delim;
        end
      end
      default: begin
      end
    endcase

    if (judged) phase_nxt = PH_DONE;

    // nul rearms for the next string
    if (cls.nul) begin
      phase_nxt = PH_WS;
      mant_nxt  = 1'b0;
      pos_nxt   = '0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + 16'd1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  assign verdict_valid      = step && judged;
  assign verdict.accepted   = ok;
  assign verdict.end_offset = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WS;
      mant_r  <= 1'b0;
      pos_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      mant_r  <= mant_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

[rtl/nlr_out_buf.sv]
module nlr_out_buf import nlr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_stall
);

  logic    main_valid_r, skid_valid_r;
  result_t main_r, skid_r;
  logic    take;

  assign take      = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || take) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= push;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || take) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
        skid_r <= push_data;
      end else begin
        main_r <= push_data;
      end
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule
